// ----- hdl/pip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int CFG_WIDTH        = 5;
    localparam int INDEX_WIDTH      = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic valid;
        logic parity;
    } pip_ctl_t;

endpackage

// ----- hdl/pip_edge_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_cell
// Holds one polygon vertex and tests the passing query word against the edge
// from the previous vertex. Two register stages: products, then parity.
// ----------------------------------------------------------------------------
module pip_edge_cell
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          wr_en,
    input  logic signed [COORD_WIDTH-1:0] wr_x,
    input  logic signed [COORD_WIDTH-1:0] wr_y,
    output logic signed [COORD_WIDTH-1:0] vert_x,
    output logic signed [COORD_WIDTH-1:0] vert_y,
    input  logic signed [COORD_WIDTH-1:0] prev_x,
    input  logic signed [COORD_WIDTH-1:0] prev_y,
    input  logic                          active,
    input  pip_ctl_t                      in_ctl,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    output pip_ctl_t                      out_ctl,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic                          busy
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_WIDTH-1:0] vx_reg, vy_reg;

    logic signed [DW-1:0] dxp, dyv, dxv, dyp;
    logic signed [PW-1:0] p1_next, p2_next;
    logic                 span_next;

    pip_ctl_t                      s1_ctl_reg;
    logic signed [COORD_WIDTH-1:0] s1_x_reg, s1_y_reg;
    logic signed [PW-1:0]          s1_p1_reg, s1_p2_reg;
    logic                          s1_hit_reg, s1_dypos_reg;

    pip_ctl_t                      s2_ctl_reg, s2_ctl_next;
    logic signed [COORD_WIDTH-1:0] s2_x_reg, s2_y_reg;
    logic                          left;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vx_reg <= wr_x;
            vy_reg <= wr_y;
        end
    end

    assign vert_x = vx_reg;
    assign vert_y = vy_reg;

    always_comb begin
        dxp       = DW'(in_x) - DW'(vx_reg);
        dyv       = DW'(prev_y) - DW'(vy_reg);
        dxv       = DW'(prev_x) - DW'(vx_reg);
        dyp       = DW'(in_y) - DW'(vy_reg);
        p1_next   = PW'(dxp) * PW'(dyv);
        p2_next   = PW'(dxv) * PW'(dyp);
        span_next = ((vy_reg <= in_y) && (in_y < prev_y)) ||
                    ((prev_y <= in_y) && (in_y < vy_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s2_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x_reg     <= in_x;
            s1_y_reg     <= in_y;
            s1_p1_reg    <= p1_next;
            s1_p2_reg    <= p2_next;
            s1_hit_reg   <= active && span_next;
            s1_dypos_reg <= prev_y > vy_reg;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
        end
    end

    always_comb begin
        left               = s1_dypos_reg ? (s1_p1_reg <= s1_p2_reg)
                                          : (s1_p1_reg >= s1_p2_reg);
        s2_ctl_next.valid  = s1_ctl_reg.valid;
        s2_ctl_next.parity = s1_ctl_reg.parity ^ (s1_hit_reg && left);
    end

    assign out_ctl = s2_ctl_reg;
    assign out_x   = s2_x_reg;
    assign out_y   = s2_y_reg;
    assign busy    = s1_ctl_reg.valid || s2_ctl_reg.valid;

endmodule

// ----- hdl/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
// A query passes through the register stages of every edge cell, then the output register, before result valid.
// Throughput: one query word per cycle; the chain stalls as a whole on m_ready.
// A vertex write waits until no query is in flight in the chain.
// Reset clears vertex_count and all valid bits; the vertex table is not cleared.
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Ray-crossing point-in-polygon test over a chain of edge cells.
// ----------------------------------------------------------------------------
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_WIDTH-1:0]          cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [INDEX_WIDTH-1:0]        s_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] s_coord_x,
    input  logic signed [COORD_WIDTH-1:0] s_coord_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_inside_res
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CMP_W  = (IDX_W + 1 > CFG_WIDTH) ? IDX_W + 1 : CFG_WIDTH;
    localparam int WCMP_W = (IDX_W > INDEX_WIDTH) ? IDX_W : INDEX_WIDTH;

    logic [CFG_WIDTH-1:0] vertex_count_reg;
    logic                 m_valid_reg, m_inside_res_reg;

    logic                 en, chain_busy, wr_fire, q_fire;
    logic [CMP_W-1:0]     count_ext;
    logic [IDX_W-1:0]     last_idx;
    logic [WCMP_W-1:0]    widx;

    logic signed [COORD_WIDTH-1:0] vx [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] vy [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] px [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] py [MAX_VERTICES];
    pip_ctl_t                      ctl [MAX_VERTICES+1];
    logic signed [COORD_WIDTH-1:0] cx  [MAX_VERTICES+1];
    logic signed [COORD_WIDTH-1:0] cy  [MAX_VERTICES+1];
    logic [MAX_VERTICES-1:0]       busy_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
        end else if (cfg_we) begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    assign en         = !m_valid_reg || m_ready;
    assign chain_busy = |busy_vec;
    assign s_ready    = en && ((s_command == CMD_QUERY) || !chain_busy);
    assign wr_fire    = s_valid && s_ready && (s_command == CMD_WRITE);
    assign q_fire     = s_valid && s_ready && (s_command == CMD_QUERY);
    assign widx       = WCMP_W'(s_vertex_index);
    assign count_ext  = CMP_W'(vertex_count_reg);

    always_comb begin
        if (count_ext >= CMP_W'(MAX_VERTICES)) begin
            last_idx = IDX_W'(MAX_VERTICES - 1);
        end else begin
            last_idx = IDX_W'(count_ext - CMP_W'(1));
        end
    end

    assign ctl[0].valid  = q_fire;
    assign ctl[0].parity = 1'b0;
    assign cx[0]         = s_coord_x;
    assign cy[0]         = s_coord_y;

    generate
        for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
            if (i == 0) begin : g_first
                assign px[i] = vx[last_idx];
                assign py[i] = vy[last_idx];
            end else begin : g_rest
                assign px[i] = vx[i-1];
                assign py[i] = vy[i-1];
            end

            pip_edge_cell #(
                .COORD_WIDTH(COORD_WIDTH)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .wr_en   (wr_fire && (widx == WCMP_W'(i))),
                .wr_x    (s_coord_x),
                .wr_y    (s_coord_y),
                .vert_x  (vx[i]),
                .vert_y  (vy[i]),
                .prev_x  (px[i]),
                .prev_y  (py[i]),
                .active  (CMP_W'(i) < count_ext),
                .in_ctl  (ctl[i]),
                .in_x    (cx[i]),
                .in_y    (cy[i]),
                .out_ctl (ctl[i+1]),
                .out_x   (cx[i+1]),
                .out_y   (cy[i+1]),
                .busy    (busy_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctl[MAX_VERTICES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_inside_res_reg <= ctl[MAX_VERTICES].parity;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_res_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the point-in-polygon crossing test. Vertex writes
// and query points go in over the s_ channel; an in-bench parity predictor
// computes the expected inside flag for every accepted query, and each word
// taken from the m_ channel is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import pip_pkg::*;

    localparam int NUM_SLOTS   = MAX_VERTICES_DEF;
    localparam int DRAIN_WAIT  = 48;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1450;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_WIDTH-1:0]          cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_command = CMD_WRITE;
    logic [INDEX_WIDTH-1:0]        s_vertex_index = '0;
    logic signed [COORD_WIDTH_DEF-1:0] s_coord_x = '0;
    logic signed [COORD_WIDTH_DEF-1:0] s_coord_y = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_inside_res;

    // predictor state
    logic signed [15:0] poly_x [NUM_SLOTS];
    logic signed [15:0] poly_y [NUM_SLOTS];
    int unsigned        vertex_total = 0;
    bit                 inside_expected [$];

    int  err_count = 0;
    int  item_total = 0;
    int  stall_cycles = 0;
    bit  idle_en = 1'b1;
    bit  took_word = 1'b0;
    int  ready_gap = 0;
    int  hold_request = 0;
    int  hold_left = 0;

    point_in_polygon_test uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_vertex_index (s_vertex_index),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_res   (m_inside_res)
    );

    always #4 aclk = ~aclk;

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] rand_coord(int span);
        if (span == 0) return 16'($urandom_range(0, 65535));
        return clip16(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // crossing parity, exact compare by cross-multiplication
    function automatic bit polygon_contains(logic signed [15:0] px, logic signed [15:0] py);
        int     n;
        int     j;
        longint qx, qy, xi, yi, xj, yj, dy, lhs, rhs;
        bit     par;
        bit     left;
        n = (vertex_total > NUM_SLOTS) ? NUM_SLOTS : vertex_total;
        par = 1'b0;
        qx = px;
        qy = py;
        if (n == 0) return 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if ((yi <= qy && qy < yj) || (yj <= qy && qy < yi)) begin
                dy = yj - yi;
                lhs = (qx - xi) * dy;
                rhs = (xj - xi) * (qy - yi);
                left = (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
                if (left) par = !par;
            end
            j = i;
        end
        return par;
    endfunction

    task automatic send_word(logic cmd, logic [3:0] idx,
                             logic signed [15:0] x, logic signed [15:0] y);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_vertex_index <= idx;
        s_coord_x      <= x;
        s_coord_y      <= y;
        do @(posedge aclk); while (!s_ready);
        item_total++;
        if (cmd == CMD_WRITE) begin
            poly_x[idx] = x;
            poly_y[idx] = y;
        end else begin
            inside_expected.push_back(polygon_contains(x, y));
        end
    endtask

    task automatic write_vertex(int idx, int x, int y);
        send_word(CMD_WRITE, idx[3:0], clip16(x), clip16(y));
    endtask

    task automatic query_point(int x, int y);
        send_word(CMD_QUERY, 4'($urandom_range(0, 15)), clip16(x), clip16(y));
    endtask

    // drop valid, let every result come back, then give the chain time to settle
    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (inside_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_vertex_count(int unsigned value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[CFG_WIDTH-1:0];
        vertex_total = value & 5'h1f;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_empty_polygon();
        set_vertex_count(0);
        query_point(0, 0);
        query_point(32767, 32767);
        query_point(-32768, -32768);
        drain_block();
    endtask

    // center, boundary and just-outside points of an axis-aligned square
    task automatic test_square();
        write_vertex(0, -100, -100);
        write_vertex(1, 100, -100);
        write_vertex(2, 100, 100);
        write_vertex(3, -100, 100);
        drain_block();
        set_vertex_count(4);
        query_point(0, 0);
        query_point(-100, 0);
        query_point(100, 0);
        query_point(0, -100);
        query_point(0, 100);
        query_point(-100, -100);
        query_point(100, 100);
        query_point(-101, 0);
        query_point(0, 101);
        drain_block();
    endtask

    task automatic test_extreme_coords();
        write_vertex(0, -32768, -32768);
        write_vertex(1, 32767, -32768);
        write_vertex(2, 0, 32767);
        drain_block();
        set_vertex_count(3);
        query_point(-32768, -32768);
        query_point(32767, 32767);
        query_point(0, 0);
        query_point(-32768, 32767);
        drain_block();
    endtask

    task automatic test_degenerate();
        set_vertex_count(1);
        query_point(-32768, -32768);
        query_point(0, 0);
        drain_block();
        set_vertex_count(2);
        query_point(0, -32768);
        query_point(0, 0);
        drain_block();
    endtask

    // receiver holds off while queries keep coming, so the chain backs up
    task automatic test_backpressure();
        write_vertex(0, -50, -40);
        write_vertex(1, 60, -30);
        write_vertex(2, 10, 70);
        drain_block();
        set_vertex_count(3);
        idle_en = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (80) query_point(int'($urandom_range(0, 160)) - 80,
                                int'($urandom_range(0, 160)) - 80);
        drain_block();
        idle_en = 1'b1;
    endtask

    task automatic test_random_polygons();
        int phase;
        int count;
        int span;
        int used;
        int k;
        phase = 0;
        while (item_total < ITEM_TARGET) begin
            case (phase)
                0:       count = 16;
                1:       count = 31;
                2:       count = 3;
                3:       count = 0;
                4:       count = 1;
                5:       count = 2;
                6:       count = 20;
                default: count = $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 2))
                0:       span = 8;
                1:       span = 1000;
                default: span = 0;
            endcase
            if (phase == 0 || phase == 1) span = 0;
            used = (count > NUM_SLOTS) ? NUM_SLOTS : count;
            for (int i = 0; i < used; i++) begin
                send_word(CMD_WRITE, i[3:0], rand_coord(span), rand_coord(span));
            end
            drain_block();
            idle_en = (phase % 4) != 3;
            set_vertex_count(count);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_word(CMD_WRITE, 4'($urandom_range(0, 15)),
                              rand_coord(span), rand_coord(span));
                end else begin
                    case ($urandom_range(0, 2))
                        0: send_word(CMD_QUERY, 4'($urandom_range(0, 15)),
                                     rand_coord(0), rand_coord(0));
                        1: begin
                            k = (used > 0) ? $urandom_range(0, used - 1) : 0;
                            send_word(CMD_QUERY, 4'($urandom_range(0, 15)),
                                      clip16(poly_x[k] + int'($urandom_range(0, 4)) - 2),
                                      clip16(poly_y[k] + int'($urandom_range(0, 4)) - 2));
                        end
                        default: send_word(CMD_QUERY, 4'($urandom_range(0, 15)),
                                           rand_coord(span), rand_coord(span));
                    endcase
                end
            end
            drain_block();
            phase++;
        end
        idle_en = 1'b1;
    endtask

    // result ready side: per-word random wait while idle_en is set, plus a long hold on request
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (took_word) begin
            took_word = 1'b0;
            ready_gap = idle_en ? $urandom_range(0, 4) : 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            took_word = 1'b1;
            if (inside_expected.size() == 0) begin
                $error("inside_res: expected no word, actual %0b", m_inside_res);
                err_count++;
            end else if (m_inside_res !== inside_expected[0]) begin
                $error("inside_res: expected %0b, actual %0b",
                       inside_expected[0], m_inside_res);
                err_count++;
                void'(inside_expected.pop_front());
            end else begin
                void'(inside_expected.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** point_in_polygon_test: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_polygon();
        test_square();
        test_extreme_coords();
        test_degenerate();
        test_backpressure();
        test_random_polygons();
        drain_block();
        if (err_count == 0) begin
            $display("** point_in_polygon_test: PASSED **");
        end else begin
            $display("** point_in_polygon_test: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pip_pkg.sv
hdl/pip_edge_cell.sv
hdl/point_in_polygon_test.sv
test/testbench.sv
